// ===== rtl/core/atsc_pkg.sv =====
// Package for the adaptive time-step controller: widths, reset values,
// register indexes, status codes and the ratio-breakpoint register group.
// No dependencies.
package atsc_pkg;

  localparam int TIME_BITS_DEF       = 48;
  localparam int RATIO_FRAC_BITS_DEF = 16;
  localparam int CHANGE_BITS         = 32;
  localparam int RATIO_REG_BITS      = 24;
  localparam int ADDR_BITS           = 6;
  localparam int DATA_BITS           = 64;

  localparam logic [2:0] REG_STEADY      = 3'd0;
  localparam logic [2:0] REG_TARGET      = 3'd1;
  localparam logic [2:0] REG_MIN_STEP    = 3'd2;
  localparam logic [2:0] REG_MAX_STEP    = 3'd3;
  localparam logic [2:0] REG_ZERO_GAIN   = 3'd4;
  localparam logic [2:0] REG_LINEAR_LOW  = 3'd5;
  localparam logic [2:0] REG_LINEAR_HIGH = 3'd6;
  localparam logic [2:0] REG_FULL_GAIN   = 3'd7;

  localparam logic [2:0] ST_UNCHANGED = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_LIMITED   = 3'd2;
  localparam logic [2:0] ST_BELOW_MIN = 3'd3;
  localparam logic [2:0] ST_BAD_INPUT = 3'd4;
  localparam logic [2:0] ST_BEHIND    = 3'd5;

  localparam logic [63:0] RESET_TARGET          = 64'd16777;
  localparam logic [63:0] RESET_MIN_STEP        = 64'd1;
  localparam logic [63:0] RESET_MAX_STEP        = 64'd1000000;
  localparam logic [RATIO_REG_BITS-1:0] RESET_Z = 24'd32768;
  localparam logic [RATIO_REG_BITS-1:0] RESET_L = 24'd58982;
  localparam logic [RATIO_REG_BITS-1:0] RESET_H = 24'd72090;
  localparam logic [RATIO_REG_BITS-1:0] RESET_F = 24'd131072;

  typedef struct packed {
    logic [RATIO_REG_BITS-1:0] z;
    logic [RATIO_REG_BITS-1:0] l;
    logic [RATIO_REG_BITS-1:0] h;
    logic [RATIO_REG_BITS-1:0] f;
  } ratio_cfg_t;

  function automatic int gain_bits(int rf);
    return (rf + 2 > RATIO_REG_BITS) ? rf + 2 : RATIO_REG_BITS;
  endfunction

endpackage

// ===== rtl/core/atsc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a tag word
// carried alongside. Flags quotients that do not fit. Depends on nothing.
module atsc_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 24,
  parameter type tag_t = logic
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  tag_t          in_tag,
  output logic          out_valid,
  output logic [QW-1:0] out_quot,
  output logic          out_sat,
  output tag_t          out_tag
);

  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic          vld  [0:QW];
  logic          sat  [0:QW];
  logic [DW-1:0] rem  [0:QW];
  logic [DW-1:0] den  [0:QW];
  logic [QW-1:0] low  [0:QW];
  logic [QW-1:0] quot [0:QW];
  tag_t          tag  [0:QW];

  logic [CW-1:0] head_x;
  logic [CW-1:0] den_x;

  assign head_x = CW'(in_num[NW-1:QW]);
  assign den_x  = CW'(in_den);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    sat[0]  <= head_x >= den_x;
    rem[0]  <= head_x[DW-1:0];
    den[0]  <= in_den;
    low[0]  <= in_num[QW-1:0];
    quot[0] <= '0;
    tag[0]  <= in_tag;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {rem[k-1], low[k-1][QW-1]};
    assign diff  = trial - {1'b0, den[k-1]};
    assign ge    = trial >= {1'b0, den[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      sat[k]  <= sat[k-1];
      rem[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      den[k]  <= den[k-1];
      low[k]  <= low[k-1] << 1;
      quot[k] <= {quot[k-1][QW-2:0], ge};
      tag[k]  <= tag[k-1];
    end
  end

  assign out_valid = vld[QW];
  assign out_quot  = quot[QW];
  assign out_sat   = sat[QW];
  assign out_tag   = tag[QW];

endmodule

// ===== rtl/core/atsc_regs.sv =====
// Configuration registers of the time-step controller behind an APB-style
// port. Depends on atsc_pkg.
module atsc_regs #(
  parameter int TIME_BITS = atsc_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [atsc_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [atsc_pkg::DATA_BITS-1:0]      pwdata,
  output logic [atsc_pkg::DATA_BITS-1:0]      prdata,
  output logic                                steady_mode,
  output logic [atsc_pkg::CHANGE_BITS-1:0]    target_change,
  output logic [TIME_BITS-1:0]                min_step,
  output logic [TIME_BITS-1:0]                max_step,
  output atsc_pkg::ratio_cfg_t                ratio_cfg
);

  logic       wr;
  logic [2:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[atsc_pkg::ADDR_BITS-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      steady_mode   <= 1'b0;
      target_change <= atsc_pkg::RESET_TARGET[atsc_pkg::CHANGE_BITS-1:0];
      min_step      <= TIME_BITS'(atsc_pkg::RESET_MIN_STEP);
      max_step      <= TIME_BITS'(atsc_pkg::RESET_MAX_STEP);
      ratio_cfg.z   <= atsc_pkg::RESET_Z;
      ratio_cfg.l   <= atsc_pkg::RESET_L;
      ratio_cfg.h   <= atsc_pkg::RESET_H;
      ratio_cfg.f   <= atsc_pkg::RESET_F;
    end else if (wr) begin
      unique case (idx)
        atsc_pkg::REG_STEADY:      steady_mode   <= pwdata[0];
        atsc_pkg::REG_TARGET:      target_change <= pwdata[atsc_pkg::CHANGE_BITS-1:0];
        atsc_pkg::REG_MIN_STEP:    min_step      <= pwdata[TIME_BITS-1:0];
        atsc_pkg::REG_MAX_STEP:    max_step      <= pwdata[TIME_BITS-1:0];
        atsc_pkg::REG_ZERO_GAIN:   ratio_cfg.z   <= pwdata[atsc_pkg::RATIO_REG_BITS-1:0];
        atsc_pkg::REG_LINEAR_LOW:  ratio_cfg.l   <= pwdata[atsc_pkg::RATIO_REG_BITS-1:0];
        atsc_pkg::REG_LINEAR_HIGH: ratio_cfg.h   <= pwdata[atsc_pkg::RATIO_REG_BITS-1:0];
        atsc_pkg::REG_FULL_GAIN:   ratio_cfg.f   <= pwdata[atsc_pkg::RATIO_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      atsc_pkg::REG_STEADY:      prdata = atsc_pkg::DATA_BITS'(steady_mode);
      atsc_pkg::REG_TARGET:      prdata = atsc_pkg::DATA_BITS'(target_change);
      atsc_pkg::REG_MIN_STEP:    prdata = atsc_pkg::DATA_BITS'(min_step);
      atsc_pkg::REG_MAX_STEP:    prdata = atsc_pkg::DATA_BITS'(max_step);
      atsc_pkg::REG_ZERO_GAIN:   prdata = atsc_pkg::DATA_BITS'(ratio_cfg.z);
      atsc_pkg::REG_LINEAR_LOW:  prdata = atsc_pkg::DATA_BITS'(ratio_cfg.l);
      atsc_pkg::REG_LINEAR_HIGH: prdata = atsc_pkg::DATA_BITS'(ratio_cfg.h);
      atsc_pkg::REG_FULL_GAIN:   prdata = atsc_pkg::DATA_BITS'(ratio_cfg.f);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/atsc_gain.sv =====
// Piecewise-linear gain pipeline: region decode, slope multiply, divide and
// final selection with the cap at two. Depends on atsc_pkg and atsc_div.
module atsc_gain #(
  parameter int RATIO_FRAC_BITS = atsc_pkg::RATIO_FRAC_BITS_DEF,
  parameter type tag_t = logic
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   in_valid,
  input  logic [RATIO_FRAC_BITS+7:0]                             in_ratio,
  input  tag_t                                                   in_tag,
  input  atsc_pkg::ratio_cfg_t                                   cfg,
  output logic                                                   out_valid,
  output logic [atsc_pkg::gain_bits(RATIO_FRAC_BITS)-1:0]       out_gain,
  output tag_t                                                   out_tag
);

  localparam int RF = RATIO_FRAC_BITS;
  localparam int RB = RF + 8;
  localparam int G  = atsc_pkg::gain_bits(RF);
  localparam int CW = (RB > atsc_pkg::RATIO_REG_BITS) ? RB : atsc_pkg::RATIO_REG_BITS;
  localparam int PW = G + RB;
  localparam int DWG = atsc_pkg::RATIO_REG_BITS;
  localparam logic [G-1:0]  TWO_G = {{(G-1){1'b0}}, 1'b1} << (RF + 1);
  localparam logic [CW-1:0] TWO_C = {{(CW-1){1'b0}}, 1'b1} << (RF + 1);

  localparam logic [2:0] GM_MID   = 3'd0;
  localparam logic [2:0] GM_ZERO  = 3'd1;
  localparam logic [2:0] GM_LOWER = 3'd2;
  localparam logic [2:0] GM_UPPER = 3'd3;
  localparam logic [2:0] GM_TWO   = 3'd4;

  typedef struct packed {
    logic [2:0]    mode;
    logic [RB-1:0] ratio;
    tag_t          tag;
  } gtag_t;

  logic [CW-1:0]  rx, zx, lx, hx, fx, two_minus_h, r_minus_z, r_minus_h;
  logic [2:0]     mode_next;
  logic [G-1:0]   a_next;
  logic [RB-1:0]  b_next;
  logic [DWG-1:0] den_next;

  logic           a_valid;
  logic [G-1:0]   a_op;
  logic [RB-1:0]  b_op;
  logic [DWG-1:0] a_den;
  gtag_t          a_gtag;

  logic           m_valid;
  logic [PW-1:0]  m_num;
  logic [DWG-1:0] m_den;
  gtag_t          m_gtag;

  logic           d_valid;
  logic [G-1:0]   d_quot;
  logic           d_sat;
  gtag_t          d_gtag;
  logic [G-1:0]   up_limit;
  logic [G-1:0]   gain_next;

  assign rx = CW'(in_ratio);
  assign zx = CW'(cfg.z);
  assign lx = CW'(cfg.l);
  assign hx = CW'(cfg.h);
  assign fx = CW'(cfg.f);
  assign two_minus_h = TWO_C - hx;
  assign r_minus_z   = rx - zx;
  assign r_minus_h   = rx - hx;

  always_comb begin
    a_next   = '0;
    b_next   = '0;
    den_next = {{(DWG-1){1'b0}}, 1'b1};
    priority if (rx < hx && rx > lx) begin
      mode_next = GM_MID;
    end else if (rx <= lx) begin
      if (lx <= zx || rx <= zx) begin
        mode_next = GM_ZERO;
      end else begin
        mode_next = GM_LOWER;
        a_next    = G'(cfg.l);
        b_next    = r_minus_z[RB-1:0];
        den_next  = cfg.l - cfg.z;
      end
    end else if (hx >= TWO_C || fx <= hx) begin
      mode_next = GM_TWO;
    end else begin
      mode_next = GM_UPPER;
      a_next    = two_minus_h[G-1:0];
      b_next    = r_minus_h[RB-1:0];
      den_next  = cfg.f - cfg.h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
      m_valid <= a_valid;
    end
    a_op        <= a_next;
    b_op        <= b_next;
    a_den       <= den_next;
    a_gtag.mode <= mode_next;
    a_gtag.ratio <= in_ratio;
    a_gtag.tag  <= in_tag;
    m_num       <= a_op * b_op;
    m_den       <= a_den;
    m_gtag      <= a_gtag;
  end

  atsc_div #(
    .NW    (PW),
    .DW    (DWG),
    .QW    (G),
    .tag_t (gtag_t)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .in_num    (m_num),
    .in_den    (m_den),
    .in_tag    (m_gtag),
    .out_valid (d_valid),
    .out_quot  (d_quot),
    .out_sat   (d_sat),
    .out_tag   (d_gtag)
  );

  assign up_limit = TWO_G - G'(cfg.h);

  always_comb begin
    unique case (d_gtag.mode)
      GM_MID:   gain_next = G'(d_gtag.ratio);
      GM_ZERO:  gain_next = '0;
      GM_LOWER: gain_next = d_quot;
      GM_UPPER: gain_next = (d_sat || d_quot > up_limit) ? TWO_G : G'(cfg.h) + d_quot;
      default:  gain_next = TWO_G;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= d_valid;
    end
    out_gain <= gain_next;
    out_tag  <= d_gtag.tag;
  end

endmodule

// ===== rtl/core/adaptive_time_step_controller_unit.sv =====
// Adaptive time-step controller, top level. Depends on atsc_pkg, atsc_regs,
// atsc_div and atsc_gain.
// The two bit-per-stage dividers set most of the pipeline depth. A new word is
// taken every cycle, so busy stays low and throughput is one word per cycle.
// Synchronous reset empties the pipeline and loads register defaults.
module adaptive_time_step_controller_unit #(
  parameter int TIME_BITS       = atsc_pkg::TIME_BITS_DEF,
  parameter int RATIO_FRAC_BITS = atsc_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [atsc_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [atsc_pkg::DATA_BITS-1:0]   pwdata,
  output logic [atsc_pkg::DATA_BITS-1:0]   prdata,
  output logic                             pready,
  input  logic                             start,
  output logic                             busy,
  input  logic                             early_iteration,
  input  logic [TIME_BITS-1:0]             step_now,
  input  logic [atsc_pkg::CHANGE_BITS-1:0] change_seen,
  input  logic                             restricted,
  input  logic [TIME_BITS-1:0]             time_now,
  input  logic [TIME_BITS-1:0]             event_time,
  output logic                             done,
  output logic [TIME_BITS-1:0]             step_next,
  output logic [2:0]                       status,
  output logic                             restriction_cleared
);

  localparam int TB = TIME_BITS;
  localparam int RF = RATIO_FRAC_BITS;
  localparam int RB = RF + 8;
  localparam int G  = atsc_pkg::gain_bits(RF);
  localparam int LO = TB / 2;
  localparam int HI = TB - LO;
  localparam int SW = TB + G;
  localparam int XW = SW - RF;

  typedef struct packed {
    logic          bypass;
    logic [2:0]    status;
    logic          cleared;
    logic [TB-1:0] step;
    logic [TB-1:0] gap;
  } tag_t;

  logic                             steady_mode;
  logic [atsc_pkg::CHANGE_BITS-1:0] target_change;
  logic [TB-1:0]                    min_step;
  logic [TB-1:0]                    max_step;
  atsc_pkg::ratio_cfg_t             ratio_cfg;

  tag_t                             in_tag;
  logic                             bad_input;
  logic                             behind;

  logic          r_valid;
  logic [RB-1:0] r_quot;
  logic          r_sat;
  tag_t          r_tag;

  logic          g_valid;
  logic [G-1:0]  g_gain;
  tag_t          g_tag;

  logic             p_valid;
  logic [LO+G-1:0]  p_lo;
  logic [HI+G-1:0]  p_hi;
  tag_t             p_tag;

  logic [SW-1:0]    full;
  logic [XW-1:0]    scaled;
  logic [TB-1:0]    clamp_next;
  logic             c_valid;
  logic [TB-1:0]    c_step;
  tag_t             c_tag;

  assign pready = 1'b1;
  assign busy   = 1'b0;

  atsc_regs #(
    .TIME_BITS (TB)
  ) u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .steady_mode   (steady_mode),
    .target_change (target_change),
    .min_step      (min_step),
    .max_step      (max_step),
    .ratio_cfg     (ratio_cfg)
  );

  assign bad_input = (change_seen == '0) || (step_now == '0);
  assign behind    = event_time <= time_now;

  always_comb begin
    in_tag.gap = event_time - time_now;
    priority if (steady_mode || early_iteration) begin
      in_tag.bypass  = 1'b1;
      in_tag.status  = atsc_pkg::ST_UNCHANGED;
      in_tag.cleared = 1'b0;
      in_tag.step    = step_now;
    end else if (bad_input) begin
      in_tag.bypass  = 1'b1;
      in_tag.status  = atsc_pkg::ST_BAD_INPUT;
      in_tag.cleared = 1'b0;
      in_tag.step    = step_now;
    end else if (behind) begin
      in_tag.bypass  = 1'b1;
      in_tag.status  = atsc_pkg::ST_BEHIND;
      in_tag.cleared = restricted;
      in_tag.step    = step_now;
    end else begin
      in_tag.bypass  = 1'b0;
      in_tag.status  = atsc_pkg::ST_UPDATED;
      in_tag.cleared = restricted;
      in_tag.step    = restricted ? min_step : step_now;
    end
  end

  atsc_div #(
    .NW    (atsc_pkg::CHANGE_BITS + RF),
    .DW    (atsc_pkg::CHANGE_BITS),
    .QW    (RB),
    .tag_t (tag_t)
  ) u_ratio_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .in_num    ({target_change, {RF{1'b0}}}),
    .in_den    (change_seen),
    .in_tag    (in_tag),
    .out_valid (r_valid),
    .out_quot  (r_quot),
    .out_sat   (r_sat),
    .out_tag   (r_tag)
  );

  atsc_gain #(
    .RATIO_FRAC_BITS (RF),
    .tag_t           (tag_t)
  ) u_gain (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .in_ratio  (r_sat ? {RB{1'b1}} : r_quot),
    .in_tag    (r_tag),
    .cfg       (ratio_cfg),
    .out_valid (g_valid),
    .out_gain  (g_gain),
    .out_tag   (g_tag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= g_valid;
    end
    p_lo  <= g_tag.step[LO-1:0] * g_gain;
    p_hi  <= g_tag.step[TB-1:LO] * g_gain;
    p_tag <= g_tag;
  end

  assign full   = {p_hi, {LO{1'b0}}} + SW'(p_lo);
  assign scaled = full[SW-1:RF];

  always_comb begin
    priority if (scaled < XW'(min_step)) begin
      clamp_next = min_step;
    end else if (scaled > XW'(max_step)) begin
      clamp_next = max_step;
    end else begin
      clamp_next = scaled[TB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= p_valid;
    end
    c_step <= clamp_next;
    c_tag  <= p_tag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_valid;
    end
    restriction_cleared <= c_tag.cleared;
    priority if (c_tag.bypass) begin
      step_next <= c_tag.step;
      status    <= c_tag.status;
    end else if (c_step > c_tag.gap) begin
      step_next <= c_tag.gap;
      status    <= (c_tag.gap < min_step) ? atsc_pkg::ST_BELOW_MIN : atsc_pkg::ST_LIMITED;
    end else begin
      step_next <= c_step;
      status    <= atsc_pkg::ST_UPDATED;
    end
  end

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= atsc_pkg::ST_BEHIND)
    else $error("status code out of range");

  a_cleared_status: assert property (@(posedge clk) disable iff (rst)
    done && restriction_cleared |->
      status != atsc_pkg::ST_UNCHANGED && status != atsc_pkg::ST_BAD_INPUT)
    else $error("restriction cleared on a pass-through word");

  a_limited_min: assert property (@(posedge clk) disable iff (rst)
    done && status == atsc_pkg::ST_LIMITED |-> step_next >= min_step)
    else $error("event-limited step below minimum");

  a_below_min: assert property (@(posedge clk) disable iff (rst)
    done && status == atsc_pkg::ST_BELOW_MIN |-> step_next < min_step)
    else $error("below-minimum status with step at or above minimum");

endmodule

// ===== dv/tb_adaptive_time_step_controller_unit.sv =====
// Self-checking testbench for adaptive_time_step_controller_unit: it predicts each
// step decision and compares every done word with the prediction, field by field.
// Depends on atsc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_adaptive_time_step_controller_unit;

  localparam logic [63:0] TWO = 64'd2 << 16;
  localparam logic [63:0] TMASK = (64'd1 << 48) - 1;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic        early;
    logic [47:0] step;
    logic [31:0] change;
    logic        restr;
    logic [47:0] now;
    logic [47:0] evt;
  } step_req_t;

  typedef struct packed {
    logic [47:0] step;
    logic [2:0]  st;
    logic        cleared;
  } step_dec_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [atsc_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [atsc_pkg::DATA_BITS-1:0] pwdata = '0;
  logic [atsc_pkg::DATA_BITS-1:0] prdata;
  logic pready, start = 0, busy, done, restriction_cleared;
  logic early_iteration = 0, restricted = 0;
  logic [47:0] step_now = '0, time_now = '0, event_time = '0, step_next;
  logic [31:0] change_seen = '0;
  logic [2:0] status;

  logic [63:0] cfg_steady, cfg_target, cfg_min, cfg_max, cfg_z, cfg_l, cfg_h, cfg_f;
  step_req_t req_q[$];
  step_dec_t dec_q[$];
  bit calm = 0, failed = 0;
  int cycles = 0;

  adaptive_time_step_controller_unit dut (.*);

  initial forever #10 clk = ~clk;

  function automatic logic [63:0] gain(logic [63:0] r);
    logic [63:0] s;
    if (r < cfg_h && r > cfg_l) return r;
    if (r <= cfg_l) begin
      if (cfg_l <= cfg_z || r <= cfg_z) return '0;
      return (cfg_l * (r - cfg_z)) / (cfg_l - cfg_z);
    end
    if (cfg_h >= TWO || cfg_f <= cfg_h) return TWO;
    s = cfg_h + ((TWO - cfg_h) * (r - cfg_h)) / (cfg_f - cfg_h);
    return s > TWO ? TWO : s;
  endfunction

  function automatic step_dec_t decide(step_req_t q);
    step_dec_t d;
    logic [63:0] st, r, s, nxt, gap;
    logic [127:0] prod;
    d.step = q.step;
    d.st = atsc_pkg::ST_UNCHANGED;
    d.cleared = 1'b0;
    st = q.step;
    if (cfg_steady[0] || q.early) return d;
    if (q.change == 0 || q.step == 0) begin
      d.st = atsc_pkg::ST_BAD_INPUT;
      return d;
    end
    if (q.restr) begin
      st = cfg_min;
      d.cleared = 1'b1;
    end
    if (q.evt <= q.now) begin
      d.st = atsc_pkg::ST_BEHIND;
      return d;
    end
    r = (cfg_target << 16) / q.change;
    if (r > 64'hFFFFFF) r = 64'hFFFFFF;
    s = gain(r);
    prod = (128'(st >> 16) * s) + ((128'(st & 64'hFFFF) * s) >> 16);
    nxt = prod[127:64] != 0 ? '1 : prod[63:0];
    if (nxt < cfg_min) nxt = cfg_min;
    else if (nxt > cfg_max) nxt = cfg_max;
    gap = q.evt - q.now;
    d.st = atsc_pkg::ST_UPDATED;
    if (nxt > gap) begin
      nxt = gap;
      d.st = gap < cfg_min ? atsc_pkg::ST_BELOW_MIN : atsc_pkg::ST_LIMITED;
    end
    d.step = nxt[47:0];
    return d;
  endfunction

  always @(posedge clk) begin
    step_req_t nx;
    bit load;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL adaptive_time_step_controller_unit");
      $finish;
    end
    if (!rst) begin
      if (start && !busy)
        dec_q.push_back(decide({early_iteration, step_now, change_seen, restricted,
                                time_now, event_time}));
      load = 0;
      if (!(start && busy) && req_q.size() > 0 && (calm || $urandom_range(99) >= 26)) begin
        nx = req_q.pop_front();
        load = 1;
        early_iteration <= nx.early;
        step_now <= nx.step;
        change_seen <= nx.change;
        restricted <= nx.restr;
        time_now <= nx.now;
        event_time <= nx.evt;
      end
      if (!(start && busy)) start <= load;
    end
  end

  always @(posedge clk) begin
    step_dec_t e;
    if (!rst && done) begin
      if (dec_q.size() == 0) begin
        $display("%0t: unexpected word step %0d status %0d", $time, step_next, status);
        failed = 1;
      end else begin
        e = dec_q.pop_front();
        if (step_next !== e.step) begin
          $display("%0t: step_next expected %0d actual %0d", $time, e.step, step_next);
          failed = 1;
        end
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          failed = 1;
        end
        if (restriction_cleared !== e.cleared) begin
          $display("%0t: restriction_cleared expected %0d actual %0d", $time, e.cleared,
                   restriction_cleared);
          failed = 1;
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= atsc_pkg::ADDR_BITS'({idx, 3'b000}); pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      atsc_pkg::REG_STEADY:      cfg_steady = val & 1;
      atsc_pkg::REG_TARGET:      cfg_target = val & 64'hFFFFFFFF;
      atsc_pkg::REG_MIN_STEP:    cfg_min = val & TMASK;
      atsc_pkg::REG_MAX_STEP:    cfg_max = val & TMASK;
      atsc_pkg::REG_ZERO_GAIN:   cfg_z = val & 64'hFFFFFF;
      atsc_pkg::REG_LINEAR_LOW:  cfg_l = val & 64'hFFFFFF;
      atsc_pkg::REG_LINEAR_HIGH: cfg_h = val & 64'hFFFFFF;
      default:                   cfg_f = val & 64'hFFFFFF;
    endcase
  endtask

  task automatic setup(logic [63:0] sm, logic [63:0] tg, logic [63:0] mn, logic [63:0] mx,
                       logic [63:0] z, logic [63:0] l, logic [63:0] h, logic [63:0] f);
    while (req_q.size() || dec_q.size() || start) @(posedge clk);
    write_reg(atsc_pkg::REG_STEADY, sm);
    write_reg(atsc_pkg::REG_TARGET, tg);
    write_reg(atsc_pkg::REG_MIN_STEP, mn);
    write_reg(atsc_pkg::REG_MAX_STEP, mx);
    write_reg(atsc_pkg::REG_ZERO_GAIN, z);
    write_reg(atsc_pkg::REG_LINEAR_LOW, l);
    write_reg(atsc_pkg::REG_LINEAR_HIGH, h);
    write_reg(atsc_pkg::REG_FULL_GAIN, f);
  endtask

  function automatic logic [47:0] r48();
    case ($urandom_range(3))
      0: return 48'({$urandom, $urandom});
      1: return 48'($urandom_range(2000000));
      2: return '1;
      default: return 48'($urandom) << $urandom_range(16);
    endcase
  endfunction

  task automatic add_random(int n);
    step_req_t q;
    logic [63:0] rt;
    repeat (n) begin
      q.early = $urandom_range(9) == 0;
      q.restr = $urandom_range(3) == 0;
      q.step = r48();
      rt = 64'($urandom_range(200000)) + 1;
      case ($urandom_range(5))
        0: q.change = $urandom;
        1: q.change = $urandom_range(3) == 0 ? 0 : 32'($urandom_range(100));
        default: q.change = 32'(((cfg_target << 16) / rt) + $urandom_range(1));
      endcase
      if ($urandom_range(19) == 0) q.step = 0;
      q.now = r48();
      if ($urandom_range(9) == 0) q.evt = $urandom_range(1) ? q.now : 48'($urandom) & q.now;
      else q.evt = q.now + 48'($urandom_range(1) ? r48() : 48'($urandom_range(5000)) + 1);
      if (q.evt <= q.now && $urandom_range(1)) q.evt = '1;
      req_q.push_back(q);
    end
  endtask

  initial begin
    cfg_steady = 0; cfg_target = atsc_pkg::RESET_TARGET; cfg_min = atsc_pkg::RESET_MIN_STEP;
    cfg_max = atsc_pkg::RESET_MAX_STEP; cfg_z = atsc_pkg::RESET_Z; cfg_l = atsc_pkg::RESET_L;
    cfg_h = atsc_pkg::RESET_H; cfg_f = atsc_pkg::RESET_F;
    repeat (12) @(posedge clk);
    rst <= 0;
    req_q.push_back({1'b1, 48'd1000, 32'd5000, 1'b0, 48'd0, 48'd100000});
    req_q.push_back({1'b0, 48'd1000, 32'd0, 1'b1, 48'd0, 48'd100000});
    req_q.push_back({1'b0, 48'd0, 32'd5000, 1'b1, 48'd0, 48'd100000});
    req_q.push_back({1'b0, 48'd1000, 32'd5000, 1'b1, 48'd500, 48'd500});
    req_q.push_back({1'b0, 48'd1000, 32'd5000, 1'b0, 48'd900, 48'd100});
    req_q.push_back({1'b0, 48'd1000, 32'd16777, 1'b0, 48'd0, 48'd100000});
    req_q.push_back({1'b0, 48'd1000, 32'd1, 1'b0, 48'd0, 48'd100000});
    req_q.push_back({1'b0, 48'd1000, 32'hFFFFFFFF, 1'b0, 48'd0, 48'd100000});
    req_q.push_back({1'b0, 48'd1000, 32'd30000, 1'b0, 48'd0, 48'd100000});
    req_q.push_back({1'b0, 48'd1000, 32'd9000, 1'b0, 48'd0, 48'd100000});
    req_q.push_back({1'b0, 48'd1000, 32'd5000, 1'b1, 48'd0, 48'd100000});
    req_q.push_back({1'b0, 48'd1000, 32'd5000, 1'b0, 48'd0, 48'd700});
    req_q.push_back({1'b0, 48'hFFFFFFFFFFFF, 32'd1, 1'b0, 48'd0, 48'hFFFFFFFFFFFF});
    req_q.push_back({1'b0, 48'hFFFFFFFFFFFF, 32'd16777, 1'b1, 48'hFFFFFFFFFFFE,
                     48'hFFFFFFFFFFFF});
    req_q.push_back({1'b1, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 1'b1, 48'hFFFFFFFFFFFF,
                     48'hFFFFFFFFFFFF});
    add_random(135);
    setup(1, 64'd16777, 1, 1000000, 32768, 58982, 72090, 131072);
    add_random(40);
    setup(0, 64'hFFFFFFFF, 1, TMASK, 20000, 50000, 90000, 200000);
    add_random(150);
    setup(0, 64'd16777, 10, 5000000, 60000, 40000, 140000, 100000);
    add_random(100);
    setup(0, 64'd16777, 5000, 100, 32768, 58982, 72090, 131072);
    add_random(100);
    setup(0, 1, TMASK, TMASK, 0, 24'hFFFFFF, 0, 24'hFFFFFF);
    add_random(50);
    setup(0, 64'd40000, 3, 64'd90000000, 24'hFFFFFF, 0, 24'hFFFFFF, 0);
    add_random(50);
    setup(0, $urandom, 64'($urandom_range(50)) + 1, 64'($urandom) + 100,
          $urandom_range(40000), 40001 + $urandom_range(30000), 70000 + $urandom_range(50000),
          100000 + $urandom_range(100000));
    calm = 1;
    add_random(110);
    while (req_q.size() || dec_q.size() || start) @(posedge clk);
    repeat (80) @(posedge clk);
    if (!failed && dec_q.size() == 0) begin
      $display("PASS adaptive_time_step_controller_unit");
    end else begin
      $display("FAIL adaptive_time_step_controller_unit");
    end
    $finish;
  end
endmodule
